// ----- rtl/core/rme_pkg.sv -----
// ============================================================================
// rme_pkg: shared types, codes and control store for the register machine
// Item and opcode codes, status codes, the datapath control word and the
// microcode table that sequences every item.
// ============================================================================
package rme_pkg;

    localparam int DATA_W    = 32;
    localparam int STEP_W    = 32;
    localparam int PC_W      = 9;
    localparam int ADDR_W    = 8;
    localparam int REG_IDX_W = 6;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

    localparam logic [OP_W-1:0] OP_NOOP = 3'd0;
    localparam logic [OP_W-1:0] OP_ZERO = 3'd1;
    localparam logic [OP_W-1:0] OP_SUCC = 3'd2;
    localparam logic [OP_W-1:0] OP_COPY = 3'd3;
    localparam logic [OP_W-1:0] OP_JEQ  = 3'd4;

    localparam logic [ST_W-1:0] ST_READ   = 2'd0;
    localparam logic [ST_W-1:0] ST_HALT   = 2'd1;
    localparam logic [ST_W-1:0] ST_LIMIT  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADREG = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT  = 1'd1;

    typedef struct packed {
        logic [ADDR_W-1:0]    target;
        logic [REG_IDX_W-1:0] b;
        logic [REG_IDX_W-1:0] a;
        logic [OP_W-1:0]      op;
    } instr_t;

    localparam int INSTR_W = $bits(instr_t);

    typedef enum logic [3:0] {
        S_IDLE     = 4'd0,
        S_LOAD     = 4'd1,
        S_WRITE    = 4'd2,
        S_RUN      = 4'd3,
        S_READ     = 4'd4,
        S_READ_OUT = 4'd5,
        S_FETCH    = 4'd6,
        S_DECODE   = 4'd7,
        S_EXEC     = 4'd8,
        S_RUN_OUT  = 4'd9
    } step_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_LOAD,
        DP_WRITE,
        DP_READ_ISSUE,
        DP_READ_OUT,
        DP_RUN_INIT,
        DP_FETCH,
        DP_DECODE,
        DP_EXEC,
        DP_RUN_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_GOTO,
        BR_KIND,
        BR_END,
        BR_BAD
    } br_t;

    typedef struct packed {
        logic   wait_in;
        logic   wait_out;
        logic   out_load;
        dp_op_t op;
        br_t    br;
        step_t  target;
    } uword_t;

    typedef struct packed {
        logic   fire;
        uword_t w;
    } ctl_t;

    typedef struct packed {
        logic end_run;
        logic bad_reg;
    } dp_flags_t;

    typedef struct packed {
        logic              in_accept;
        logic [KIND_W-1:0] kind;
        logic              out_free;
        dp_flags_t         flags;
    } seq_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [ST_W-1:0]   run_status;
        logic [STEP_W-1:0] steps_taken;
        logic [PC_W-1:0]   final_counter;
    } res_t;

    function automatic uword_t uw(logic wi, logic wo, logic ol, dp_op_t op, br_t br,
                                  step_t tg);
        return '{wait_in: wi, wait_out: wo, out_load: ol, op: op, br: br, target: tg};
    endfunction

    function automatic uword_t ucode_rom(step_t s);
        uword_t w;
        unique case (s)
            S_IDLE:     w = uw(1'b1, 1'b0, 1'b0, DP_LATCH,      BR_KIND, S_LOAD);
            S_LOAD:     w = uw(1'b0, 1'b0, 1'b0, DP_LOAD,       BR_GOTO, S_IDLE);
            S_WRITE:    w = uw(1'b0, 1'b0, 1'b0, DP_WRITE,      BR_GOTO, S_IDLE);
            S_RUN:      w = uw(1'b0, 1'b0, 1'b0, DP_RUN_INIT,   BR_GOTO, S_FETCH);
            S_READ:     w = uw(1'b0, 1'b0, 1'b0, DP_READ_ISSUE, BR_NEXT, S_IDLE);
            S_READ_OUT: w = uw(1'b0, 1'b1, 1'b1, DP_READ_OUT,   BR_GOTO, S_IDLE);
            S_FETCH:    w = uw(1'b0, 1'b0, 1'b0, DP_FETCH,      BR_END,  S_RUN_OUT);
            S_DECODE:   w = uw(1'b0, 1'b0, 1'b0, DP_DECODE,     BR_BAD,  S_RUN_OUT);
            S_EXEC:     w = uw(1'b0, 1'b0, 1'b0, DP_EXEC,       BR_GOTO, S_FETCH);
            S_RUN_OUT:  w = uw(1'b0, 1'b1, 1'b1, DP_RUN_OUT,    BR_GOTO, S_IDLE);
            default:    w = uw(1'b0, 1'b0, 1'b0, DP_NONE,       BR_GOTO, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/register_machine_executor.sv -----
// ============================================================================
// register_machine_executor: microcoded register machine
// Loads instructions, writes and reads registers, and runs loaded programs
// under a step limit, one item at a time through a microcode sequencer.
//
//   channel  handshake            beat contents
//   -------  -------------------  ----------------------------------------
//   in       in_valid / in_stall  kind, prog_address, opcode, first_reg,
//                                 second_reg, jump_target, reg_index,
//                                 reg_value
//   out      out_valid/out_stall  read_value, run_status, steps_taken,
//                                 final_counter
//   cfg      cfg_write            cfg_index, cfg_data
//
// Load and write items are latched, then stored; read items are latched,
// issued and then output. A run initialises, then takes each instruction
// through fetch, decode and execute via the single-read program store and
// the register file RAMs, and ends in its output step.
// Reset leaves the register file reading zero through per-entry valid flags;
// no clearing pass. The program store is undefined until loaded.
// A new item is accepted while a result beat waits; a read or run holds in
// its output step until the output register is free.
// ============================================================================
module register_machine_executor #(
    parameter int PROG_DEPTH = 256,
    parameter int REG_COUNT  = 64,
    parameter int REG_WIDTH  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rme_pkg::KIND_W-1:0]          kind,
    input  logic [rme_pkg::ADDR_W-1:0]          prog_address,
    input  logic [rme_pkg::OP_W-1:0]            opcode,
    input  logic [rme_pkg::REG_IDX_W-1:0]       first_reg,
    input  logic [rme_pkg::REG_IDX_W-1:0]       second_reg,
    input  logic [rme_pkg::ADDR_W-1:0]          jump_target,
    input  logic [rme_pkg::REG_IDX_W-1:0]       reg_index,
    input  logic [rme_pkg::DATA_W-1:0]          reg_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rme_pkg::DATA_W-1:0]          read_value,
    output logic [rme_pkg::ST_W-1:0]            run_status,
    output logic [rme_pkg::STEP_W-1:0]          steps_taken,
    output logic [rme_pkg::PC_W-1:0]            final_counter,
    input  logic                                cfg_write,
    input  logic [rme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rme_pkg::STEP_W-1:0]          cfg_data
);

    rme_pkg::ctl_t      ctl;
    rme_pkg::seq_in_t   sin;
    rme_pkg::dp_flags_t flags;
    rme_pkg::res_t      res;
    rme_pkg::res_t      out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_free;
    logic               out_load;

    assign in_stall = !ctl.w.wait_in;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = ctl.fire && ctl.w.out_load;

    assign sin = '{in_accept: in_valid && !in_stall, kind: kind, out_free: out_free,
                   flags: flags};

    rme_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sin   (sin),
        .ctl   (ctl)
    );

    rme_datapath #(
        .PROG_DEPTH (PROG_DEPTH),
        .REG_COUNT  (REG_COUNT),
        .REG_WIDTH  (REG_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .prog_address (prog_address),
        .opcode       (opcode),
        .first_reg    (first_reg),
        .second_reg   (second_reg),
        .jump_target  (jump_target),
        .reg_index    (reg_index),
        .reg_value    (reg_value),
        .flags        (flags),
        .res          (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_value    = out_reg.read_value;
    assign run_status    = out_reg.run_status;
    assign steps_taken   = out_reg.steps_taken;
    assign final_counter = out_reg.final_counter;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("result beat loaded but not presented");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (run_status == rme_pkg::ST_READ))
        |-> ((steps_taken == '0) && (final_counter == '0)))
        else $error("read result carries run fields");

    a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (run_status == rme_pkg::ST_HALT)) |-> (final_counter != '0))
        else $error("halted run with zero counter");

endmodule

// ----- rtl/core/rme_ram.sv -----
// ============================================================================
// rme_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and held while
// the read enable is low.
// ============================================================================
module rme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rme_sequencer.sv -----
// ============================================================================
// rme_sequencer: microcode step counter and branch unit
// Holds the current step, looks up its control word and picks the next step
// from sequential, jump, kind-dispatch or conditional branch fields.
// ============================================================================
module rme_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  rme_pkg::seq_in_t sin,
    output rme_pkg::ctl_t    ctl
);

    rme_pkg::step_t  step_reg;
    rme_pkg::step_t  step_next;
    rme_pkg::uword_t w;
    logic            fire;

    always_comb
    begin
        w    = rme_pkg::ucode_rom(step_reg);
        fire = (!w.wait_in || sin.in_accept) && (!w.wait_out || sin.out_free);
        ctl  = '{fire: fire, w: w};
    end

    always_comb
    begin
        step_next = step_reg;
        if (fire)
        begin
            unique case (w.br)
                rme_pkg::BR_NEXT: step_next = rme_pkg::step_t'(4'(step_reg) + 4'd1);
                rme_pkg::BR_GOTO: step_next = w.target;
                rme_pkg::BR_KIND: step_next = rme_pkg::step_t'(4'(w.target) + 4'(sin.kind));
                rme_pkg::BR_END:  step_next = sin.flags.end_run ? w.target
                                            : rme_pkg::step_t'(4'(step_reg) + 4'd1);
                rme_pkg::BR_BAD:  step_next = sin.flags.bad_reg ? w.target
                                            : rme_pkg::step_t'(4'(step_reg) + 4'd1);
                default:          step_next = rme_pkg::S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= rme_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- rtl/core/rme_datapath.sv -----
// ============================================================================
// rme_datapath: program store, register file, counters and result forming
// Executes the datapath operation named by the control word; reports the
// run-end and bad-register conditions back to the sequencer.
// ============================================================================
module rme_datapath #(
    parameter int PROG_DEPTH = 256,
    parameter int REG_COUNT  = 64,
    parameter int REG_WIDTH  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rme_pkg::ctl_t                       ctl,
    input  logic                                cfg_write,
    input  logic [rme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rme_pkg::STEP_W-1:0]          cfg_data,
    input  logic [rme_pkg::ADDR_W-1:0]          prog_address,
    input  logic [rme_pkg::OP_W-1:0]            opcode,
    input  logic [rme_pkg::REG_IDX_W-1:0]       first_reg,
    input  logic [rme_pkg::REG_IDX_W-1:0]       second_reg,
    input  logic [rme_pkg::ADDR_W-1:0]          jump_target,
    input  logic [rme_pkg::REG_IDX_W-1:0]       reg_index,
    input  logic [rme_pkg::DATA_W-1:0]          reg_value,
    output rme_pkg::dp_flags_t                  flags,
    output rme_pkg::res_t                       res
);

    localparam int PROG_SPAN = (PROG_DEPTH < (1 << rme_pkg::ADDR_W)) ? PROG_DEPTH
                             : (1 << rme_pkg::ADDR_W);
    localparam int REG_SPAN  = (REG_COUNT < (1 << rme_pkg::REG_IDX_W)) ? REG_COUNT
                             : (1 << rme_pkg::REG_IDX_W);
    localparam int PA_W = (PROG_SPAN > 1) ? $clog2(PROG_SPAN) : 1;
    localparam int RA_W = (REG_SPAN > 1) ? $clog2(REG_SPAN) : 1;
    localparam int INSTR_BITS = rme_pkg::INSTR_W;

    logic [rme_pkg::ADDR_W-1:0]    addr_reg;
    rme_pkg::instr_t               load_reg;
    logic [rme_pkg::REG_IDX_W-1:0] ri_reg;
    logic [rme_pkg::DATA_W-1:0]    value_reg;
    logic [rme_pkg::PC_W-1:0]      pc_reg;
    logic [rme_pkg::PC_W-1:0]      pc_next;
    logic [rme_pkg::STEP_W-1:0]    steps_reg;
    logic [rme_pkg::ST_W-1:0]      status_reg;
    logic                          fetch_ok_reg;
    rme_pkg::instr_t               ins_reg;
    logic [rme_pkg::ADDR_W-1:0]    len_reg;
    logic [rme_pkg::STEP_W-1:0]    limit_reg;
    logic [REG_SPAN-1:0]           reg_valid_reg;
    logic                          valid_a_reg;
    logic                          valid_b_reg;

    logic do_latch, do_load, do_write, do_read_issue, do_run_init;
    logic do_fetch, do_decode, do_exec;

    logic                  prog_we;
    logic [INSTR_BITS-1:0] prog_rdata;
    rme_pkg::instr_t       word;
    logic                  halt_c, limit_c;
    logic                  a_bad, b_bad, uses_a, uses_b;
    logic                  ri_ok;

    logic                 reg_we;
    logic [RA_W-1:0]      reg_waddr;
    logic [REG_WIDTH-1:0] reg_wdata;
    logic                 reg_re;
    logic [RA_W-1:0]      raddr_a;
    logic [RA_W-1:0]      raddr_b;
    logic [REG_WIDTH-1:0] rdata_a;
    logic [REG_WIDTH-1:0] rdata_b;
    logic [REG_WIDTH-1:0] va;
    logic [REG_WIDTH-1:0] vb;

    assign do_latch      = ctl.fire && (ctl.w.op == rme_pkg::DP_LATCH);
    assign do_load       = ctl.fire && (ctl.w.op == rme_pkg::DP_LOAD);
    assign do_write      = ctl.fire && (ctl.w.op == rme_pkg::DP_WRITE);
    assign do_read_issue = ctl.fire && (ctl.w.op == rme_pkg::DP_READ_ISSUE);
    assign do_run_init   = ctl.fire && (ctl.w.op == rme_pkg::DP_RUN_INIT);
    assign do_fetch      = ctl.fire && (ctl.w.op == rme_pkg::DP_FETCH);
    assign do_decode     = ctl.fire && (ctl.w.op == rme_pkg::DP_DECODE);
    assign do_exec       = ctl.fire && (ctl.w.op == rme_pkg::DP_EXEC);

    // program store
    assign prog_we = do_load && (addr_reg != '0) && (32'(addr_reg) < PROG_DEPTH);

    rme_ram #(
        .WIDTH (INSTR_BITS),
        .DEPTH (PROG_SPAN)
    ) u_prog (
        .clk   (clk),
        .we    (prog_we),
        .waddr (addr_reg[PA_W-1:0]),
        .wdata (load_reg),
        .re    (do_fetch),
        .raddr (pc_reg[PA_W-1:0]),
        .rdata (prog_rdata)
    );

    assign word = fetch_ok_reg ? rme_pkg::instr_t'(prog_rdata) : '0;

    assign halt_c  = pc_reg > {1'b0, len_reg};
    assign limit_c = ((limit_reg != '0) && (steps_reg >= limit_reg)) || (&steps_reg);

    assign uses_a = (word.op == rme_pkg::OP_ZERO) || (word.op == rme_pkg::OP_SUCC)
                 || (word.op == rme_pkg::OP_COPY) || (word.op == rme_pkg::OP_JEQ);
    assign uses_b = (word.op == rme_pkg::OP_COPY) || (word.op == rme_pkg::OP_JEQ);
    assign a_bad  = 32'(word.a) >= REG_COUNT;
    assign b_bad  = 32'(word.b) >= REG_COUNT;

    assign flags.end_run = halt_c || limit_c;
    assign flags.bad_reg = (uses_a && a_bad) || (uses_b && b_bad);

    assign ri_ok = 32'(ri_reg) < REG_COUNT;

    // register file: two copies give both compare operands in one read
    assign reg_re  = do_read_issue || do_decode;
    assign raddr_a = do_read_issue ? ri_reg[RA_W-1:0] : word.a[RA_W-1:0];
    assign raddr_b = word.b[RA_W-1:0];

    assign va = valid_a_reg ? rdata_a : '0;
    assign vb = valid_b_reg ? rdata_b : '0;

    always_comb
    begin
        reg_we    = 1'b0;
        reg_waddr = ins_reg.a[RA_W-1:0];
        reg_wdata = '0;
        if (do_write && ri_ok)
        begin
            reg_we    = 1'b1;
            reg_waddr = ri_reg[RA_W-1:0];
            reg_wdata = REG_WIDTH'(value_reg);
        end
        else if (do_exec)
        begin
            case (ins_reg.op)
                rme_pkg::OP_ZERO:
                begin
                    reg_we    = 1'b1;
                    reg_waddr = ins_reg.a[RA_W-1:0];
                    reg_wdata = '0;
                end
                rme_pkg::OP_SUCC:
                begin
                    reg_we    = 1'b1;
                    reg_waddr = ins_reg.a[RA_W-1:0];
                    reg_wdata = va + REG_WIDTH'(1);
                end
                rme_pkg::OP_COPY:
                begin
                    reg_we    = 1'b1;
                    reg_waddr = ins_reg.b[RA_W-1:0];
                    reg_wdata = va;
                end
                default:
                begin
                    reg_we = 1'b0;
                end
            endcase
        end
    end

    rme_ram #(
        .WIDTH (REG_WIDTH),
        .DEPTH (REG_SPAN)
    ) u_regs_a (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (reg_re),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    rme_ram #(
        .WIDTH (REG_WIDTH),
        .DEPTH (REG_SPAN)
    ) u_regs_b (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (reg_re),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    always_comb
    begin
        pc_next = pc_reg + 9'd1;
        if ((ins_reg.op == rme_pkg::OP_JEQ) && (va == vb))
        begin
            pc_next = {1'b0, ins_reg.target};
        end
    end

    // item capture and instruction latch: payload, no reset
    always_ff @(posedge clk)
    begin
        if (do_latch)
        begin
            addr_reg  <= prog_address;
            load_reg  <= '{target: jump_target, b: second_reg, a: first_reg, op: opcode};
            ri_reg    <= reg_index;
            value_reg <= reg_value;
        end
        if (do_decode)
        begin
            ins_reg <= word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= 9'd1;
            steps_reg     <= '0;
            status_reg    <= rme_pkg::ST_HALT;
            fetch_ok_reg  <= 1'b0;
            len_reg       <= '0;
            limit_reg     <= '0;
            reg_valid_reg <= '0;
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    rme_pkg::CFG_PROG_LENGTH: len_reg   <= cfg_data[rme_pkg::ADDR_W-1:0];
                    rme_pkg::CFG_STEP_LIMIT:  limit_reg <= cfg_data;
                    default:                  len_reg   <= len_reg;
                endcase
            end
            if (reg_we)
            begin
                reg_valid_reg[reg_waddr] <= 1'b1;
            end
            if (reg_re)
            begin
                valid_a_reg <= reg_valid_reg[raddr_a];
                valid_b_reg <= reg_valid_reg[raddr_b];
            end
            if (do_run_init)
            begin
                pc_reg    <= 9'd1;
                steps_reg <= '0;
            end
            if (do_fetch)
            begin
                fetch_ok_reg <= (pc_reg != '0) && (32'(pc_reg) < PROG_DEPTH);
                if (halt_c)
                begin
                    status_reg <= rme_pkg::ST_HALT;
                end
                else if (limit_c)
                begin
                    status_reg <= rme_pkg::ST_LIMIT;
                end
            end
            if (do_decode && flags.bad_reg)
            begin
                status_reg <= rme_pkg::ST_BADREG;
            end
            if (do_exec)
            begin
                pc_reg    <= pc_next;
                steps_reg <= steps_reg + 32'd1;
            end
        end
    end

    always_comb
    begin
        if (ctl.w.op == rme_pkg::DP_READ_OUT)
        begin
            res.read_value    = ri_ok ? rme_pkg::DATA_W'(va) : '0;
            res.run_status    = ri_ok ? rme_pkg::ST_READ : rme_pkg::ST_BADREG;
            res.steps_taken   = '0;
            res.final_counter = '0;
        end
        else
        begin
            res.read_value    = '0;
            res.run_status    = status_reg;
            res.steps_taken   = steps_reg;
            res.final_counter = pc_reg;
        end
    end

endmodule
